// ===== rtl/core/rgbwenc_pkg.sv =====
// ----------------------------------------------------------------------------
// rgbwenc_pkg
// Shared types and constants for the RGBW LED SPI bit encoder.
// ----------------------------------------------------------------------------
package rgbwenc_pkg;

    localparam int MAX_PIXELS_DEF   = 512;
    localparam int NUM_CHANNELS_DEF = 2;

    localparam int COLOR_W      = 8;
    localparam int PIX_W        = 10;
    localparam int TOTAL_W      = 13;
    localparam int LANES        = 4;
    localparam int LANE_BYTES   = 3;
    localparam int SYM_BYTES    = LANES * LANE_BYTES;
    localparam int SYM_BITS     = 3 * COLOR_W;
    localparam int SLOT_W       = 4;

    localparam logic [2:0]         SYM_ONE    = 3'b110;
    localparam logic [2:0]         SYM_ZERO   = 3'b100;
    localparam logic [COLOR_W-1:0] FRAME_BYTE = 8'h00;

    // Output slots of one item: opening zero, twelve symbol bytes, closing zero
    localparam logic [SLOT_W-1:0] SLOT_OPEN      = 4'd0;
    localparam logic [SLOT_W-1:0] SLOT_FIRST_SYM = 4'd1;
    localparam logic [SLOT_W-1:0] SLOT_LAST_SYM  = 4'd12;
    localparam logic [SLOT_W-1:0] SLOT_CLOSE     = 4'd13;

    typedef struct packed {
        logic               ch;
        logic               opening;
        logic               have_pixel;
        logic               last;
        logic [TOTAL_W-1:0] total;
        logic               overflow;
        logic               emit;
    } frame_info_t;

    typedef struct packed {
        frame_info_t                        info;
        logic [SYM_BYTES-1:0][COLOR_W-1:0]  sym;
    } pkt_t;

endpackage

// ===== rtl/core/rgbwenc_lane.sv =====
// ----------------------------------------------------------------------------
// rgbwenc_lane
// Expands one colour byte into 24 bits of 3-bit SPI symbols, MSB first.
// ----------------------------------------------------------------------------
module rgbwenc_lane
(
    input  logic [rgbwenc_pkg::COLOR_W-1:0]  color,
    output logic [rgbwenc_pkg::SYM_BITS-1:0] symbols
);
    import rgbwenc_pkg::*;

    always_comb
    begin
        for (int i = 0; i < COLOR_W; i++)
        begin
            symbols[3*i +: 3] = color[i] ? SYM_ONE : SYM_ZERO;
        end
    end

endmodule

// ===== rtl/core/rgbwenc_frame.sv =====
// ----------------------------------------------------------------------------
// rgbwenc_frame
// Per-channel frame bookkeeping: open flag, byte and pixel tallies, drop flag.
// ----------------------------------------------------------------------------
module rgbwenc_frame
#(
    parameter int MAX_PIXELS   = rgbwenc_pkg::MAX_PIXELS_DEF,
    parameter int NUM_CHANNELS = rgbwenc_pkg::NUM_CHANNELS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     accept,
    input  logic                     channel,
    input  logic                     last_pixel,
    output rgbwenc_pkg::frame_info_t info
);
    import rgbwenc_pkg::*;

    localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic               open_reg    [NUM_CHANNELS];
    logic [TOTAL_W-1:0] bytes_reg   [NUM_CHANNELS];
    logic [PIX_W-1:0]   pixels_reg  [NUM_CHANNELS];
    logic               dropped_reg [NUM_CHANNELS];

    logic               ch_ok;
    logic [CH_IDX_W-1:0] ch_idx;
    logic               opening;
    logic [PIX_W-1:0]   pix_cur;
    logic [TOTAL_W-1:0] bytes_cur;
    logic               have_pixel;
    logic               dropped_next;
    logic [PIX_W-1:0]   pixels_next;
    logic [TOTAL_W-1:0] bytes_next;
    logic               open_next;

    always_comb
    begin
        ch_ok        = (32'(channel) < NUM_CHANNELS);
        ch_idx       = ch_ok ? CH_IDX_W'(channel) : '0;
        opening      = !open_reg[ch_idx];
        pix_cur      = opening ? '0 : pixels_reg[ch_idx];
        bytes_cur    = opening ? TOTAL_W'(1) : bytes_reg[ch_idx];
        have_pixel   = (pix_cur < PIX_W'(MAX_PIXELS));
        dropped_next = (!opening && dropped_reg[ch_idx]) || !have_pixel;
        pixels_next  = have_pixel ? pix_cur + PIX_W'(1) : pix_cur;
        bytes_next   = have_pixel ? bytes_cur + TOTAL_W'(SYM_BYTES) : bytes_cur;
        // closing zero counts toward the frame total
        if (last_pixel)
        begin
            bytes_next = bytes_next + TOTAL_W'(1);
        end
        open_next = !last_pixel;

        info.ch         = channel;
        info.opening    = opening;
        info.have_pixel = have_pixel;
        info.last       = last_pixel;
        info.total      = bytes_next;
        info.overflow   = dropped_next;
        info.emit       = ch_ok && (opening || have_pixel || last_pixel);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                open_reg[c]    <= 1'b0;
                bytes_reg[c]   <= '0;
                pixels_reg[c]  <= '0;
                dropped_reg[c] <= 1'b0;
            end
        end
        else if (accept && ch_ok)
        begin
            open_reg[ch_idx]    <= open_next;
            bytes_reg[ch_idx]   <= bytes_next;
            pixels_reg[ch_idx]  <= pixels_next;
            dropped_reg[ch_idx] <= dropped_next;
        end
    end

endmodule

// ===== rtl/core/rgbwenc_serializer.sv =====
// ----------------------------------------------------------------------------
// rgbwenc_serializer
// Walks the slots of one encoded item and drives one output byte per cycle while out_stall is low.
// ----------------------------------------------------------------------------
module rgbwenc_serializer
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              load_valid,
    input  rgbwenc_pkg::pkt_t                 load_pkt,
    output logic                              load_take,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              channel_out,
    output logic [rgbwenc_pkg::COLOR_W-1:0]   data_byte,
    output logic                              last_byte,
    output logic [rgbwenc_pkg::TOTAL_W-1:0]   total_bytes,
    output logic                              overflow
);
    import rgbwenc_pkg::*;

    pkt_t              pkt_reg;
    logic              busy_reg;
    logic              busy_next;
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;
    logic [SLOT_W-1:0] slot_adv;
    logic [SLOT_W-1:0] slot_start;
    logic              slot_done;
    logic              fire;
    logic              is_sym;

    always_comb
    begin
        fire = busy_reg && !out_stall;

        // advance to the next slot that this item actually uses
        slot_adv  = slot_reg + SLOT_W'(1);
        slot_done = 1'b0;
        if (slot_reg == SLOT_CLOSE)
        begin
            slot_done = 1'b1;
        end
        else if (slot_reg == SLOT_OPEN && !pkt_reg.info.have_pixel)
        begin
            slot_adv  = SLOT_CLOSE;
            slot_done = !pkt_reg.info.last;
        end
        else if (slot_reg == SLOT_LAST_SYM)
        begin
            slot_done = !pkt_reg.info.last;
        end

        if (load_pkt.info.opening)
        begin
            slot_start = SLOT_OPEN;
        end
        else if (load_pkt.info.have_pixel)
        begin
            slot_start = SLOT_FIRST_SYM;
        end
        else
        begin
            slot_start = SLOT_CLOSE;
        end

        load_take = load_valid && (!busy_reg || (fire && slot_done));

        busy_next = busy_reg;
        slot_next = slot_reg;
        if (load_take)
        begin
            busy_next = 1'b1;
            slot_next = slot_start;
        end
        else if (fire)
        begin
            busy_next = !slot_done;
            slot_next = slot_adv;
        end
    end

    always_comb
    begin
        is_sym      = slot_reg inside {[SLOT_FIRST_SYM:SLOT_LAST_SYM]};
        out_valid   = busy_reg;
        channel_out = pkt_reg.info.ch;
        data_byte   = is_sym ? pkt_reg.sym[slot_reg - SLOT_FIRST_SYM] : FRAME_BYTE;
        last_byte   = (slot_reg == SLOT_CLOSE);
        total_bytes = last_byte ? pkt_reg.info.total : '0;
        overflow    = pkt_reg.info.overflow;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            slot_reg <= SLOT_OPEN;
        end
        else
        begin
            busy_reg <= busy_next;
            slot_reg <= slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_take)
        begin
            pkt_reg <= load_pkt;
        end
    end

    a_close_needs_last: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && slot_reg == SLOT_CLOSE |-> pkt_reg.info.last)
        else $error("closing slot reached on an item not marked last");

    a_open_needs_opening: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && slot_reg == SLOT_OPEN |-> pkt_reg.info.opening)
        else $error("opening slot reached on an item that opens no frame");

    a_sym_needs_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && is_sym |-> pkt_reg.info.have_pixel)
        else $error("symbol byte emitted for a dropped pixel");

    a_stall_holds_slot: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && out_stall |=> busy_reg && $stable(slot_reg))
        else $error("slot moved while the output was stalled");

endmodule

// ===== rtl/core/rgbw_led_spi_bit_encoder.sv =====
// ----------------------------------------------------------------------------
// rgbw_led_spi_bit_encoder
// RGBW pixel to 3-bit SPI symbol byte stream, one frame per channel.
// ----------------------------------------------------------------------------
// Input channel: one RGBW pixel per item (in_valid / in_stall), tagged with
// its channel and a last_pixel mark. Output channel: one SPI byte per item
// (out_valid / out_stall) with its channel, the closing mark, the frame byte
// total on the closing byte, and the frame's overflow flag.
// Each pixel is sent green, red, blue, white; four lanes expand the colours
// in parallel into twelve symbol bytes, and the merge registers them into a
// one-item buffer. Framing zeros are added before a frame's first pixel and
// after its last one.
// Path: buffer register, then the serializer's packet register, then output.
// Throughput: the serializer drains one byte per cycle while out_stall is low;
// a pixel gives twelve symbol bytes plus one per framing zero (up to 14). Pixels
// that produce no byte (dropped, not opening, not last) never fill the buffer.
// Reset clears all frame state: every channel starts with no frame open.
// When the receiver stalls, the current byte holds; one encoded pixel waits
// in the buffer, and in_stall rises once that buffer is full.
// ----------------------------------------------------------------------------
module rgbw_led_spi_bit_encoder
#(
    parameter int MAX_PIXELS   = rgbwenc_pkg::MAX_PIXELS_DEF,
    parameter int NUM_CHANNELS = rgbwenc_pkg::NUM_CHANNELS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              channel,
    input  logic [rgbwenc_pkg::COLOR_W-1:0]   red,
    input  logic [rgbwenc_pkg::COLOR_W-1:0]   green,
    input  logic [rgbwenc_pkg::COLOR_W-1:0]   blue,
    input  logic [rgbwenc_pkg::COLOR_W-1:0]   white,
    input  logic                              last_pixel,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              channel_out,
    output logic [rgbwenc_pkg::COLOR_W-1:0]   data_byte,
    output logic                              last_byte,
    output logic [rgbwenc_pkg::TOTAL_W-1:0]   total_bytes,
    output logic                              overflow
);
    import rgbwenc_pkg::*;

    logic                    accept;
    frame_info_t             info;
    logic [COLOR_W-1:0]      lane_in  [LANES];
    logic [SYM_BITS-1:0]     lane_out [LANES];
    pkt_t                    pkt_merged;
    pkt_t                    buf_reg;
    logic                    buf_valid_reg;
    logic                    buf_valid_next;
    logic                    buf_take;

    assign in_stall = buf_valid_reg;
    assign accept   = in_valid && !in_stall;

    rgbwenc_frame #(
        .MAX_PIXELS   (MAX_PIXELS),
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_frame (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .channel    (channel),
        .last_pixel (last_pixel),
        .info       (info)
    );

    assign lane_in[0] = green;
    assign lane_in[1] = red;
    assign lane_in[2] = blue;
    assign lane_in[3] = white;

    for (genvar j = 0; j < LANES; j++)
    begin : g_lane
        rgbwenc_lane u_lane (
            .color   (lane_in[j]),
            .symbols (lane_out[j])
        );
    end

    // merge: lane order, most significant byte of each lane first
    always_comb
    begin
        pkt_merged.info = info;
        for (int j = 0; j < LANES; j++)
        begin
            for (int m = 0; m < LANE_BYTES; m++)
            begin
                pkt_merged.sym[j*LANE_BYTES + m] =
                    lane_out[j][SYM_BITS-1-COLOR_W*m -: COLOR_W];
            end
        end
    end

    always_comb
    begin
        buf_valid_next = buf_valid_reg;
        if (buf_take)
        begin
            buf_valid_next = 1'b0;
        end
        else if (accept && info.emit)
        begin
            buf_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_valid_reg <= 1'b0;
        end
        else
        begin
            buf_valid_reg <= buf_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            buf_reg <= pkt_merged;
        end
    end

    rgbwenc_serializer u_ser (
        .clk         (clk),
        .rst_n       (rst_n),
        .load_valid  (buf_valid_reg),
        .load_pkt    (buf_reg),
        .load_take   (buf_take),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .channel_out (channel_out),
        .data_byte   (data_byte),
        .last_byte   (last_byte),
        .total_bytes (total_bytes),
        .overflow    (overflow)
    );

endmodule

// ===== dv/rgbw_led_spi_bit_encoder_tb.sv =====
// ----------------------------------------------------------------------------
// rgbw_led_spi_bit_encoder_tb
// Self-checking testbench for the RGBW pixel to SPI symbol byte encoder.
// ----------------------------------------------------------------------------
// Pixels go in over the valid/stall input channel, first from a short table
// (frame open and close on each channel, all-zero and all-one colours,
// single-bit colours) and then as random frames on both channels. One long
// frame on channel 0 runs while channel 1 keeps interleaving its own frames.
// A frame encoder in the testbench tracks each channel's frame and produces
// the expected SPI bytes; every byte taken from the output channel is
// compared field by field with the oldest expected byte. Both sides idle and
// stall at random, apart from one stretch where neither does.
// ----------------------------------------------------------------------------
module rgbw_led_spi_bit_encoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rgbwenc_pkg::*;

    localparam int IDLE_PCT     = 38;
    localparam int STUCK_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 30;
    localparam int N_DIRECTED   = 15;

    typedef struct packed {
        logic               ch;
        logic [COLOR_W-1:0] data;
        logic               last;
        logic [TOTAL_W-1:0] total;
        logic               ovf;
    } spi_byte_t;

    typedef struct packed {
        logic                ch;
        logic [COLOR_W-1:0]  r;
        logic [COLOR_W-1:0]  g;
        logic [COLOR_W-1:0]  b;
        logic [COLOR_W-1:0]  w;
        logic                last;
        logic                typed;  // expected bytes are given in the row
        logic                opens;  // row opens a frame (typed rows only)
        logic [SYM_BITS-1:0] sym;    // symbols shared by all four colours
        logic [TOTAL_W-1:0]  total;  // closing byte total (typed rows only)
    } pixel_row_t;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               in_valid    = 1'b0;
    logic               in_stall;
    logic               channel     = 1'b0;
    logic [COLOR_W-1:0] red         = '0;
    logic [COLOR_W-1:0] green       = '0;
    logic [COLOR_W-1:0] blue        = '0;
    logic [COLOR_W-1:0] white       = '0;
    logic               last_pixel  = 1'b0;
    logic               out_valid;
    logic               out_stall   = 1'b0;
    logic               channel_out;
    logic [COLOR_W-1:0] data_byte;
    logic               last_byte;
    logic [TOTAL_W-1:0] total_bytes;
    logic               overflow;

    // Frame state per channel, as the encoder should hold it
    logic               frame_active  [2] = '{1'b0, 1'b0};
    logic [TOTAL_W-1:0] frame_bytes   [2] = '{'0, '0};
    logic [PIX_W-1:0]   frame_pixels  [2] = '{'0, '0};
    logic               frame_dropped [2] = '{1'b0, 1'b0};

    spi_byte_t spi_bytes_due [$];
    spi_byte_t due;
    int        frame_left [2] = '{0, 0};
    int        mismatches     = 0;
    int        stuck_cycles   = 0;
    bit        quiet          = 1'b0;

    pixel_row_t directed_rows [N_DIRECTED] = '{
        '{1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 1'b1, 24'h924924, 13'd14},
        '{1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1, 24'hDB6DB6, 13'd14},
        '{1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 1'b1, 24'h924924, 13'd0},
        '{1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1, 1'b0, 24'hDB6DB6, 13'd0},
        '{1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 1'b0, 24'h924924, 13'd38},
        '{1'b1, 8'hAA, 8'h55, 8'h0F, 8'hF0, 1'b0, 1'b0, 1'b0, 24'h0, 13'd0},
        '{1'b0, 8'h80, 8'h01, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 24'h0, 13'd0},
        '{1'b1, 8'h01, 8'h80, 8'hFF, 8'h00, 1'b0, 1'b0, 1'b0, 24'h0, 13'd0},
        '{1'b0, 8'h00, 8'h00, 8'h80, 8'h01, 1'b1, 1'b0, 1'b0, 24'h0, 13'd0},
        '{1'b1, 8'h5A, 8'hA5, 8'hC3, 8'h3C, 1'b1, 1'b0, 1'b0, 24'h0, 13'd0},
        '{1'b1, 8'h12, 8'h34, 8'h56, 8'h78, 1'b1, 1'b0, 1'b0, 24'h0, 13'd0},
        '{1'b0, 8'hFE, 8'h7F, 8'hEF, 8'hF7, 1'b0, 1'b0, 1'b0, 24'h0, 13'd0},
        '{1'b1, 8'h00, 8'hFF, 8'h00, 8'hFF, 1'b0, 1'b0, 1'b0, 24'h0, 13'd0},
        '{1'b0, 8'h7F, 8'hFE, 8'h01, 8'h80, 1'b1, 1'b0, 1'b0, 24'h0, 13'd0},
        '{1'b1, 8'hFF, 8'h00, 8'hFF, 8'h00, 1'b1, 1'b0, 1'b0, 24'h0, 13'd0}
    };

    rgbw_led_spi_bit_encoder DUT
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .channel     (channel),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .white       (white),
        .last_pixel  (last_pixel),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .channel_out (channel_out),
        .data_byte   (data_byte),
        .last_byte   (last_byte),
        .total_bytes (total_bytes),
        .overflow    (overflow)
    );

    always #4 clk = ~clk;

    function automatic logic [SYM_BITS-1:0] symbols_of(input logic [COLOR_W-1:0] v);
        logic [SYM_BITS-1:0] s;
        s = '0;
        for (int i = COLOR_W - 1; i >= 0; i--)
        begin
            s = {s[SYM_BITS-4:0], v[i] ? SYM_ONE : SYM_ZERO};
        end
        return s;
    endfunction

    // Advance the channel's frame by one pixel; queue its bytes when keep is set
    task automatic encode_pixel(input pixel_row_t p, input bit keep);
        logic [COLOR_W-1:0]  colour [4];
        logic [SYM_BITS-1:0] s;
        logic                opening;
        logic                fits;
        colour[0] = p.g;
        colour[1] = p.r;
        colour[2] = p.b;
        colour[3] = p.w;
        opening = !frame_active[p.ch];
        if (opening)
        begin
            frame_active[p.ch]  = 1'b1;
            frame_bytes[p.ch]   = TOTAL_W'(1);
            frame_pixels[p.ch]  = '0;
            frame_dropped[p.ch] = 1'b0;
        end
        fits = frame_pixels[p.ch] < MAX_PIXELS_DEF;
        if (!fits)
            frame_dropped[p.ch] = 1'b1;
        if (opening && keep)
            spi_bytes_due.push_back(spi_byte_t'{p.ch, FRAME_BYTE, 1'b0, TOTAL_W'(0),
                                                frame_dropped[p.ch]});
        if (fits)
        begin
            for (int j = 0; j < LANES; j++)
            begin
                s = symbols_of(colour[j]);
                for (int k = LANE_BYTES - 1; k >= 0; k--)
                begin
                    if (keep)
                        spi_bytes_due.push_back(spi_byte_t'{p.ch, s[COLOR_W*k +: COLOR_W],
                                                            1'b0, TOTAL_W'(0),
                                                            frame_dropped[p.ch]});
                end
            end
            frame_pixels[p.ch] = frame_pixels[p.ch] + 1'b1;
            frame_bytes[p.ch]  = frame_bytes[p.ch] + TOTAL_W'(SYM_BYTES);
        end
        if (p.last)
        begin
            frame_bytes[p.ch] = frame_bytes[p.ch] + 1'b1;
            if (keep)
                spi_bytes_due.push_back(spi_byte_t'{p.ch, FRAME_BYTE, 1'b1,
                                                    frame_bytes[p.ch], frame_dropped[p.ch]});
            frame_active[p.ch] = 1'b0;
        end
    endtask

    task automatic send_pixel(input pixel_row_t p);
        @(negedge clk);
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid   <= 1'b0;
            channel    <= 1'($urandom);
            red        <= COLOR_W'($urandom);
            green      <= COLOR_W'($urandom);
            blue       <= COLOR_W'($urandom);
            white      <= COLOR_W'($urandom);
            last_pixel <= 1'($urandom);
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        channel    <= p.ch;
        red        <= p.r;
        green      <= p.g;
        blue       <= p.b;
        white      <= p.w;
        last_pixel <= p.last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        encode_pixel(p, !p.typed);
        if (p.typed)
        begin
            if (p.opens)
                spi_bytes_due.push_back(spi_byte_t'{p.ch, FRAME_BYTE, 1'b0, TOTAL_W'(0), 1'b0});
            repeat (LANES)
            begin
                for (int k = LANE_BYTES - 1; k >= 0; k--)
                    spi_bytes_due.push_back(spi_byte_t'{p.ch, p.sym[COLOR_W*k +: COLOR_W],
                                                        1'b0, TOTAL_W'(0), 1'b0});
            end
            if (p.last)
                spi_bytes_due.push_back(spi_byte_t'{p.ch, FRAME_BYTE, 1'b1, p.total, 1'b0});
        end
    endtask

    function automatic logic [COLOR_W-1:0] rand_colour();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return COLOR_W'($urandom);
        endcase
    endfunction

    // Next pixel of the channel's current random frame; start a new frame when done
    function automatic pixel_row_t next_pixel(input logic ch);
        pixel_row_t p;
        if (frame_left[ch] == 0)
            frame_left[ch] = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                                          : $urandom_range(1, 8);
        p      = '0;
        p.ch   = ch;
        p.r    = rand_colour();
        p.g    = rand_colour();
        p.b    = rand_colour();
        p.w    = rand_colour();
        p.last = (frame_left[ch] == 1);
        frame_left[ch]--;
        return p;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(negedge clk)
    begin
        out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (spi_bytes_due.size() == 0)
            begin
                $error("data_byte: expected nothing, got 0x%0h on channel %0d",
                       data_byte, channel_out);
                mismatches++;
            end
            else
            begin
                due = spi_bytes_due.pop_front();
                check_field("channel_out", due.ch, channel_out);
                check_field("data_byte", due.data, data_byte);
                check_field("last_byte", due.last, last_byte);
                check_field("total_bytes", due.total, total_bytes);
                check_field("overflow", due.ovf, overflow);
            end
        end
    end

    // Drop the run when neither side moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            stuck_cycles <= 0;
        else if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("rgbw_led_spi_bit_encoder_tb: FAIL");
            $finish;
        end
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_pixel(directed_rows[i]);

        for (int n = 0; n < 120; n++)
            send_pixel(next_pixel(1'($urandom)));

        // Stretch channel 0's frame while channel 1 interleaves its own
        frame_left[0] += $urandom_range(60, 90);
        while (frame_left[0] != 0)
            send_pixel(next_pixel($urandom_range(0, 3) == 0));

        quiet = 1'b1;
        for (int n = 0; n < 60; n++)
            send_pixel(next_pixel(1'($urandom)));
        quiet = 1'b0;

        for (int n = 0; n < 130; n++)
            send_pixel(next_pixel(1'($urandom)));

        @(negedge clk);
        in_valid <= 1'b0;
        while (spi_bytes_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("rgbw_led_spi_bit_encoder_tb: PASS");
        else
            $display("rgbw_led_spi_bit_encoder_tb: FAIL");
        $finish;
    end

endmodule
